@@ hdl/uwf_pkg.sv @@
package uwf_pkg;

  localparam int FifoDepth = 16;
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_PERIOD  = 3'd0,
    CFG_NBITS   = 3'd1,
    CFG_PARITY  = 3'd2,
    CFG_RX_THR  = 3'd3,
    CFG_TX_THR  = 3'd4,
    CFG_IRQ_EN  = 3'd5
  } cfg_idx_t;

  localparam int FL_RXNE   = 0;
  localparam int FL_RXTHR  = 1;
  localparam int FL_RXFULL = 2;
  localparam int FL_OVF    = 3;
  localparam int FL_PAR    = 4;
  localparam int FL_FRAME  = 5;
  localparam int FL_TXE    = 6;
  localparam int FL_TXNF   = 7;
  localparam int FL_TXTHR  = 8;
  localparam int FL_DONE   = 9;
  localparam int FlagCount = 10;

  localparam logic [1:0] PAR_ODD  = 2'd1;
  localparam logic [1:0] PAR_EVEN = 2'd2;

  localparam int FalseStartBits = 20;

  typedef struct packed {
    logic [1:0] cmd;
    logic       rx_line;
    logic [7:0] tx_byte;
    logic [3:0] flag_index;
  } in_word_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       tx_room;
    logic [9:0] status_flags;
    logic       irq;
  } out_word_t;

  // receiver events handed to the flag logic
  typedef struct packed {
    logic deliver;
    logic parity_err;
    logic framing_err;
  } rx_evt_t;

endpackage

@@ hdl/uwf_if.sv @@
interface uwf_in_if;
  logic              valid;
  logic              ready;
  uwf_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uwf_out_if;
  logic               valid;
  logic               ready;
  uwf_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/uwf_rx.sv @@
module uwf_rx (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             line,
  input  logic [16:0]      period,
  input  logic [3:0]       nbits,
  input  logic [1:0]       parity_mode,
  output logic [7:0]       shift,
  output uwf_pkg::rx_evt_t evt
);

  typedef enum logic [2:0] {
    S_IDLE, S_HALF, S_DATA, S_PAR, S_STOP, S_WAIT, S_FALSE
  } rx_state_t;

  rx_state_t   state, state_next;
  logic [20:0] cnt, cnt_next;
  logic [3:0]  idx, idx_next;
  logic        par, par_next;
  logic [7:0]  shift_next;
  logic        prev;
  logic [20:0] dec;
  logic        done;
  logic [20:0] per21;
  logic [20:0] false_len;
  logic        par_on;

  assign per21 = {4'd0, period};
  // 20 * period = 16p + 4p
  assign false_len = (per21 << 4) + (per21 << 2);
  assign dec = (cnt != '0) ? cnt - 21'd1 : cnt;
  assign done = (dec == '0);
  assign par_on = (parity_mode == uwf_pkg::PAR_ODD) || (parity_mode == uwf_pkg::PAR_EVEN);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    idx_next = idx;
    par_next = par;
    shift_next = shift;
    evt = '0;
    case (state)
      S_IDLE: begin
        if (prev && !line) begin
          state_next = S_HALF;
          cnt_next = per21 >> 1;
        end
      end
      S_HALF: begin
        cnt_next = dec;
        if (done) begin
          if (line) begin
            state_next = S_FALSE;
            cnt_next = false_len;
          end else begin
            state_next = S_DATA;
            cnt_next = per21;
            idx_next = '0;
            shift_next = '0;
            par_next = 1'b0;
          end
        end
      end
      S_DATA: begin
        cnt_next = dec;
        if (done) begin
          if (line && idx < 4'd8) begin
            shift_next[idx[2:0]] = 1'b1;
            par_next = ~par;
          end
          idx_next = idx + 4'd1;
          cnt_next = per21;
          if (idx + 4'd1 >= nbits) state_next = par_on ? S_PAR : S_STOP;
        end
      end
      S_PAR: begin
        cnt_next = dec;
        if (done) begin
          par_next = par ^ line;
          if ((parity_mode == uwf_pkg::PAR_ODD && (par ^ line) == 1'b0) ||
              (parity_mode == uwf_pkg::PAR_EVEN && (par ^ line) == 1'b1))
            evt.parity_err = 1'b1;
          cnt_next = per21;
          state_next = S_STOP;
        end
      end
      S_STOP: begin
        cnt_next = dec;
        if (done) begin
          if (!line) begin
            evt.framing_err = 1'b1;
            state_next = S_WAIT;
          end else begin
            evt.deliver = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        if (line) begin
          evt.deliver = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FALSE: begin
        cnt_next = dec;
        if (done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (!step) evt = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      idx <= '0;
      par <= 1'b0;
      shift <= '0;
      prev <= 1'b1;
    end else if (step) begin
      state <= state_next;
      cnt <= cnt_next;
      idx <= idx_next;
      par <= par_next;
      shift <= shift_next;
      prev <= line;
    end
  end

endmodule

@@ hdl/uart_with_fifos_and_irq_flags_top.sv @@
// uart with 16-entry receive and transmit fifos and ten sticky status flags
//
// in channel: one word per clock tick of the bit timer. it carries cmd (tick,
//   push tx byte, pop rx byte, clear flag), the rx line level, the byte to
//   push and the flag index to clear
// out channel: one word per input word: tx line, popped byte and its valid,
//   tx room, status flags and irq, all as they stand after that tick
// config: cfg_we / cfg_index / cfg_data write one register per cycle; the user
//   writes only while the block is idle, which the block itself does not enforce
//
// result: each result word is registered and appears in the cycle after its input word is accepted.
// throughput: one word per cycle unless stalled; every tick is handled by a
//   single pass of the access, rx and tx logic into the result register
// stalls: the result register holds while out.ready is low; in.ready is high
//   whenever the result register is empty or being taken, so a stalled
//   receiver stops the bit timer too (ticks are words)
// reset: fifos empty, receiver and transmitter idle with the line high,
//   flags tx empty, tx not full and tx threshold set, config at defaults
module uart_with_fifos_and_irq_flags_top (
  input  logic        clk,
  input  logic        rst,
  uwf_in_if.sink      in,
  uwf_out_if.source   out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW = uwf_pkg::PtrW;
  localparam int CW = uwf_pkg::CntW;
  localparam logic [CW-1:0] DEPTH = CW'(uwf_pkg::FifoDepth);

  // config registers
  logic [15:0] bit_period_ticks;
  logic [3:0]  data_bit_count;
  logic [1:0]  parity_mode;
  logic [4:0]  rx_level_threshold;
  logic [4:0]  tx_level_threshold;
  logic [9:0]  irq_enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks <= 16'd2604;
      data_bit_count <= 4'd8;
      parity_mode <= 2'd0;
      rx_level_threshold <= 5'd1;
      tx_level_threshold <= 5'd1;
      irq_enable_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        uwf_pkg::CFG_PERIOD: bit_period_ticks <= cfg_data;
        uwf_pkg::CFG_NBITS:  data_bit_count <= cfg_data[3:0];
        uwf_pkg::CFG_PARITY: parity_mode <= cfg_data[1:0];
        uwf_pkg::CFG_RX_THR: rx_level_threshold <= cfg_data[4:0];
        uwf_pkg::CFG_TX_THR: tx_level_threshold <= cfg_data[4:0];
        uwf_pkg::CFG_IRQ_EN: irq_enable_mask <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // clamped config
  logic [16:0] period;
  logic [3:0]  nbits;
  logic        par_on;
  assign period = (bit_period_ticks < 16'd2) ? 17'd2 : {1'b0, bit_period_ticks};
  assign nbits = (data_bit_count == 4'd0) ? 4'd1 :
                 (data_bit_count > 4'd8) ? 4'd8 : data_bit_count;
  assign par_on = (parity_mode == uwf_pkg::PAR_ODD) || (parity_mode == uwf_pkg::PAR_EVEN);

  // handshake
  logic step;
  assign in.ready = !out.valid || out.ready;
  assign step = in.valid && in.ready;

  uwf_pkg::in_word_t w;
  assign w = in.data;

  // fifos
  logic [7:0]    rx_mem [uwf_pkg::FifoDepth];
  logic [7:0]    tx_mem [uwf_pkg::FifoDepth];
  logic [PW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [CW-1:0] rx_cnt, tx_cnt;
  logic [9:0]    flags;

  // receiver
  logic [7:0]       rx_shift;
  uwf_pkg::rx_evt_t rx_evt;

  uwf_rx u_rx (
    .clk(clk), .rst(rst), .step(step), .line(w.rx_line),
    .period(period), .nbits(nbits), .parity_mode(parity_mode),
    .shift(rx_shift), .evt(rx_evt)
  );

  // transmitter
  typedef enum logic [2:0] {T_IDLE, T_START, T_DATA, T_PAR, T_STOP} tx_state_t;
  tx_state_t   tx_state, tx_state_next;
  logic [16:0] tx_tc, tx_tc_next;
  logic [3:0]  tx_idx, tx_idx_next;
  logic        tx_par, tx_par_next;
  logic [7:0]  tx_shift, tx_shift_next;
  logic        tx_level, tx_level_next;

  logic [9:0]    fl;
  logic          do_push, do_pop, rx_push, tx_take;
  logic [CW-1:0] rx_cnt_a, tx_cnt_a, rx_cnt_next, tx_cnt_next;
  logic [7:0]    popped;
  logic [16:0]   tx_dec;
  logic [3:0]    tx_idx_inc;

  assign popped = rx_mem[rx_head];
  assign tx_dec = (tx_tc != '0) ? tx_tc - 17'd1 : tx_tc;
  assign tx_idx_inc = tx_idx + 4'd1;

  always_comb begin
    fl = flags;
    do_push = 1'b0;
    do_pop = 1'b0;
    rx_cnt_a = rx_cnt;
    tx_cnt_a = tx_cnt;
    // access
    case (w.cmd)
      uwf_pkg::CMD_PUSH: begin
        if (tx_cnt < DEPTH) begin
          do_push = 1'b1;
          tx_cnt_a = tx_cnt + CW'(1);
          fl[uwf_pkg::FL_TXE] = 1'b0;
          if (tx_cnt_a >= DEPTH) fl[uwf_pkg::FL_TXNF] = 1'b0;
          if ({{(8-CW){1'b0}}, tx_cnt_a} > {3'd0, tx_level_threshold})
            fl[uwf_pkg::FL_TXTHR] = 1'b0;
        end
      end
      uwf_pkg::CMD_POP: begin
        if (rx_cnt != '0) begin
          do_pop = 1'b1;
          rx_cnt_a = rx_cnt - CW'(1);
          fl[uwf_pkg::FL_RXFULL] = 1'b0;
          if (rx_cnt_a == '0) fl[uwf_pkg::FL_RXNE] = 1'b0;
          if ({{(8-CW){1'b0}}, rx_cnt_a} < {3'd0, rx_level_threshold})
            fl[uwf_pkg::FL_RXTHR] = 1'b0;
        end
      end
      uwf_pkg::CMD_CLEAR: begin
        if (w.flag_index <= 4'd9) fl[w.flag_index] = 1'b0;
      end
      default: ;
    endcase
    // receiver events
    rx_push = 1'b0;
    rx_cnt_next = rx_cnt_a;
    if (rx_evt.parity_err) fl[uwf_pkg::FL_PAR] = 1'b1;
    if (rx_evt.framing_err) fl[uwf_pkg::FL_FRAME] = 1'b1;
    if (rx_evt.deliver) begin
      if (rx_cnt_a >= DEPTH) fl[uwf_pkg::FL_OVF] = 1'b1;
      else begin
        rx_push = 1'b1;
        rx_cnt_next = rx_cnt_a + CW'(1);
      end
      fl[uwf_pkg::FL_RXNE] = 1'b1;
      if ({{(8-CW){1'b0}}, rx_cnt_next} >= {3'd0, rx_level_threshold})
        fl[uwf_pkg::FL_RXTHR] = 1'b1;
      if (rx_cnt_next >= DEPTH) fl[uwf_pkg::FL_RXFULL] = 1'b1;
    end
    // transmitter
    tx_state_next = tx_state;
    tx_tc_next = tx_tc;
    tx_idx_next = tx_idx;
    tx_par_next = tx_par;
    tx_shift_next = tx_shift;
    tx_level_next = tx_level;
    tx_take = 1'b0;
    tx_cnt_next = tx_cnt_a;
    if (tx_state != T_IDLE) begin
      tx_tc_next = tx_dec;
      if (tx_dec == '0) begin
        tx_tc_next = period;
        case (tx_state)
          T_START: begin
            tx_idx_next = '0;
            tx_level_next = tx_shift[0];
            tx_par_next = tx_shift[0];
            tx_state_next = T_DATA;
          end
          T_DATA: begin
            tx_idx_next = tx_idx_inc;
            if (tx_idx_inc < nbits && tx_idx_inc < 4'd8) begin
              tx_level_next = tx_shift[tx_idx_inc[2:0]];
              tx_par_next = tx_par ^ tx_shift[tx_idx_inc[2:0]];
            end else if (par_on) begin
              tx_level_next = (parity_mode == uwf_pkg::PAR_ODD) ? ~tx_par : tx_par;
              tx_state_next = T_PAR;
            end else begin
              tx_level_next = 1'b1;
              tx_state_next = T_STOP;
            end
          end
          T_PAR: begin
            tx_level_next = 1'b1;
            tx_state_next = T_STOP;
          end
          default: begin
            if (tx_cnt_a == '0) fl[uwf_pkg::FL_DONE] = 1'b1;
            tx_level_next = 1'b1;
            tx_state_next = T_IDLE;
          end
        endcase
      end
    end
    if (tx_state_next == T_IDLE && tx_cnt_a != '0) begin
      tx_take = 1'b1;
      tx_cnt_next = tx_cnt_a - CW'(1);
      // a byte pushed this tick into an empty fifo bypasses the store
      tx_shift_next = (tx_cnt == '0) ? w.tx_byte : tx_mem[tx_head];
      fl[uwf_pkg::FL_TXNF] = 1'b1;
      if ({{(8-CW){1'b0}}, tx_cnt_next} <= {3'd0, tx_level_threshold})
        fl[uwf_pkg::FL_TXTHR] = 1'b1;
      if (tx_cnt_next == '0) fl[uwf_pkg::FL_TXE] = 1'b1;
      tx_level_next = 1'b0;
      tx_state_next = T_START;
      tx_tc_next = period;
    end
  end

  always_ff @(posedge clk) begin
    if (step && do_push) tx_mem[tx_tail] <= w.tx_byte;
    if (step && rx_push) rx_mem[rx_tail] <= rx_shift;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head <= '0; rx_tail <= '0; rx_cnt <= '0;
      tx_head <= '0; tx_tail <= '0; tx_cnt <= '0;
      flags <= 10'd448;
      tx_state <= T_IDLE;
      tx_tc <= '0;
      tx_idx <= '0;
      tx_par <= 1'b0;
      tx_shift <= '0;
      tx_level <= 1'b1;
      out.valid <= 1'b0;
    end else begin
      if (step) begin
        if (do_push) tx_tail <= tx_tail + PW'(1);
        if (tx_take) tx_head <= tx_head + PW'(1);
        if (do_pop) rx_head <= rx_head + PW'(1);
        if (rx_push) rx_tail <= rx_tail + PW'(1);
        rx_cnt <= rx_cnt_next;
        tx_cnt <= tx_cnt_next;
        flags <= fl;
        tx_state <= tx_state_next;
        tx_tc <= tx_tc_next;
        tx_idx <= tx_idx_next;
        tx_par <= tx_par_next;
        tx_shift <= tx_shift_next;
        tx_level <= tx_level_next;
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out.data.tx_line <= tx_level_next;
      out.data.rx_byte <= do_pop ? popped : 8'd0;
      out.data.rx_byte_valid <= do_pop;
      out.data.tx_room <= tx_cnt_next < DEPTH;
      out.data.status_flags <= fl;
      out.data.irq <= |(fl & irq_enable_mask);
    end
  end

  // fifo counts never exceed the depth
  a_rx_cnt: assert property (@(posedge clk) disable iff (rst) rx_cnt <= DEPTH)
    else $error("rx count overflow");
  a_tx_cnt: assert property (@(posedge clk) disable iff (rst) tx_cnt <= DEPTH)
    else $error("tx count overflow");
  // idle transmitter keeps the line high
  a_tx_idle: assert property (@(posedge clk) disable iff (rst)
    tx_state == T_IDLE |-> tx_level)
    else $error("tx line low while idle");
  // a result without a step keeps its valid until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid)
    else $error("result dropped");

endmodule

@@ test/uwf_checker.sv @@
`timescale 1ns / 1ps

// watches both channels and the config port, predicts every result word
module uwf_checker
  import uwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  uwf_in_if           in_ch,
  uwf_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef enum int {RX_IDLE, RX_HALF, RX_DATA, RX_PAR, RX_STOP, RX_WAIT, RX_FALSE} rx_phase_t;
  typedef enum int {TX_IDLE, TX_START, TX_DATA, TX_PAR, TX_STOP} tx_phase_t;

  // configuration copy
  int unsigned bit_ticks, nbits_cfg, par_cfg, rx_thr, tx_thr;
  logic [9:0]  irq_mask;

  // fifos
  logic [7:0]  rx_mem [FifoDepth];
  logic [7:0]  tx_mem [FifoDepth];
  int unsigned rx_head, rx_tail, rx_cnt, tx_head, tx_tail, tx_cnt;

  // serial state
  rx_phase_t   rx_ph;
  tx_phase_t   tx_ph;
  int unsigned rx_idx, rx_par, rx_shift, rx_prev, rx_ctr;
  int unsigned tx_idx, tx_par, tx_shift, tx_lvl, tx_ctr;
  logic [9:0]  flags;

  out_word_t   expected_words[$];

  assign pending = expected_words.size();

  function automatic int unsigned eff_period();
    return bit_ticks < 2 ? 2 : bit_ticks;
  endfunction

  function automatic int unsigned eff_nbits();
    if (nbits_cfg < 1) return 1;
    if (nbits_cfg > 8) return 8;
    return nbits_cfg;
  endfunction

  function automatic bit parity_on();
    return par_cfg == PAR_ODD || par_cfg == PAR_EVEN;
  endfunction

  function automatic bit rx_timer_done();
    if (rx_ctr > 0) rx_ctr--;
    return rx_ctr == 0;
  endfunction

  function automatic void reset_model();
    bit_ticks = 2604; nbits_cfg = 8; par_cfg = 0; rx_thr = 1; tx_thr = 1; irq_mask = '0;
    rx_head = 0; rx_tail = 0; rx_cnt = 0; tx_head = 0; tx_tail = 0; tx_cnt = 0;
    rx_ph = RX_IDLE; rx_idx = 0; rx_par = 0; rx_shift = 0; rx_prev = 1; rx_ctr = 0;
    tx_ph = TX_IDLE; tx_idx = 0; tx_par = 0; tx_shift = 0; tx_lvl = 1; tx_ctr = 0;
    flags = '0;
    flags[FL_TXE] = 1'b1; flags[FL_TXNF] = 1'b1; flags[FL_TXTHR] = 1'b1;
  endfunction

  // received byte lands in the fifo or sets the overflow flag
  function automatic void store_rx_byte();
    if (rx_cnt >= FifoDepth) flags[FL_OVF] = 1'b1;
    else begin
      rx_mem[rx_tail] = rx_shift[7:0];
      rx_tail = (rx_tail + 1) % FifoDepth;
      rx_cnt++;
    end
    flags[FL_RXNE] = 1'b1;
    if (rx_cnt >= rx_thr) flags[FL_RXTHR] = 1'b1;
    if (rx_cnt >= FifoDepth) flags[FL_RXFULL] = 1'b1;
  endfunction

  function automatic void rx_advance(logic line);
    case (rx_ph)
      RX_IDLE: if (rx_prev && !line) begin
        rx_ph = RX_HALF;
        rx_ctr = eff_period() >> 1;
      end
      RX_HALF: if (rx_timer_done()) begin
        if (line) begin
          rx_ph = RX_FALSE;
          rx_ctr = FalseStartBits * eff_period();
        end else begin
          rx_ph = RX_DATA; rx_ctr = eff_period();
          rx_idx = 0; rx_shift = 0; rx_par = 0;
        end
      end
      RX_DATA: if (rx_timer_done()) begin
        if (line && rx_idx < 8) begin
          rx_shift |= 1 << rx_idx;
          rx_par ^= 1;
        end
        rx_idx++;
        rx_ctr = eff_period();
        if (rx_idx >= eff_nbits()) rx_ph = parity_on() ? RX_PAR : RX_STOP;
      end
      RX_PAR: if (rx_timer_done()) begin
        rx_par ^= line;
        if ((par_cfg == PAR_ODD && rx_par == 0) || (par_cfg == PAR_EVEN && rx_par == 1))
          flags[FL_PAR] = 1'b1;
        rx_ctr = eff_period();
        rx_ph = RX_STOP;
      end
      RX_STOP: if (rx_timer_done()) begin
        if (!line) begin
          flags[FL_FRAME] = 1'b1;
          rx_ph = RX_WAIT;
        end else begin
          store_rx_byte();
          rx_ph = RX_IDLE;
        end
      end
      RX_WAIT: if (line) begin
        store_rx_byte();
        rx_ph = RX_IDLE;
      end
      default: if (rx_timer_done()) rx_ph = RX_IDLE;
    endcase
    rx_prev = line;
  endfunction

  function automatic void tx_advance();
    if (tx_ph != TX_IDLE) begin
      if (tx_ctr > 0) tx_ctr--;
      if (tx_ctr == 0) begin
        tx_ctr = eff_period();
        case (tx_ph)
          TX_START: begin
            tx_idx = 0; tx_lvl = tx_shift & 1; tx_par = tx_lvl; tx_ph = TX_DATA;
          end
          TX_DATA: begin
            tx_idx++;
            if (tx_idx < eff_nbits() && tx_idx < 8) begin
              tx_lvl = (tx_shift >> tx_idx) & 1;
              tx_par ^= tx_lvl;
            end else if (parity_on()) begin
              tx_lvl = (par_cfg == PAR_ODD) ? (tx_par ^ 1) : tx_par;
              tx_ph = TX_PAR;
            end else begin
              tx_lvl = 1; tx_ph = TX_STOP;
            end
          end
          TX_PAR: begin
            tx_lvl = 1; tx_ph = TX_STOP;
          end
          default: begin
            if (tx_cnt == 0) flags[FL_DONE] = 1'b1;
            tx_lvl = 1; tx_ph = TX_IDLE;
          end
        endcase
      end
    end
    if (tx_ph == TX_IDLE && tx_cnt > 0) begin
      tx_shift = tx_mem[tx_head];
      tx_head = (tx_head + 1) % FifoDepth;
      tx_cnt--;
      flags[FL_TXNF] = 1'b1;
      if (tx_cnt <= tx_thr) flags[FL_TXTHR] = 1'b1;
      if (tx_cnt == 0) flags[FL_TXE] = 1'b1;
      tx_lvl = 0; tx_ph = TX_START; tx_ctr = eff_period();
    end
  endfunction

  // one tick: access, then receiver, then transmitter
  function automatic out_word_t uart_tick(in_word_t w);
    out_word_t r;
    r = '0;
    case (cmd_t'(w.cmd))
      CMD_PUSH: if (tx_cnt < FifoDepth) begin
        tx_mem[tx_tail] = w.tx_byte;
        tx_tail = (tx_tail + 1) % FifoDepth;
        tx_cnt++;
        flags[FL_TXE] = 1'b0;
        if (tx_cnt >= FifoDepth) flags[FL_TXNF] = 1'b0;
        if (tx_cnt > tx_thr) flags[FL_TXTHR] = 1'b0;
      end
      CMD_POP: if (rx_cnt > 0) begin
        r.rx_byte = rx_mem[rx_head];
        r.rx_byte_valid = 1'b1;
        rx_head = (rx_head + 1) % FifoDepth;
        rx_cnt--;
        flags[FL_RXFULL] = 1'b0;
        if (rx_cnt == 0) flags[FL_RXNE] = 1'b0;
        if (rx_cnt < rx_thr) flags[FL_RXTHR] = 1'b0;
      end
      CMD_CLEAR: if (w.flag_index < FlagCount) flags[w.flag_index] = 1'b0;
      default: ;
    endcase
    rx_advance(w.rx_line);
    tx_advance();
    r.tx_line = tx_lvl[0];
    r.tx_room = tx_cnt < FifoDepth;
    r.status_flags = flags;
    r.irq = |(flags & irq_mask);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want, got;
    if (rst) begin
      reset_model();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PERIOD: bit_ticks = cfg_data;
          CFG_NBITS:  nbits_cfg = cfg_data[3:0];
          CFG_PARITY: par_cfg = cfg_data[1:0];
          CFG_RX_THR: rx_thr = cfg_data[4:0];
          CFG_TX_THR: tx_thr = cfg_data[4:0];
          CFG_IRQ_EN: irq_mask = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got.tx_line !== want.tx_line || got.rx_byte !== want.rx_byte ||
              got.rx_byte_valid !== want.rx_byte_valid || got.tx_room !== want.tx_room ||
              got.status_flags !== want.status_flags || got.irq !== want.irq) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: exp txl=%b rxb=%h v=%b room=%b fl=%h irq=%b",
                       $time, want.tx_line, want.rx_byte, want.rx_byte_valid,
                       want.tx_room, want.status_flags, want.irq);
              $display("  got txl=%b rxb=%h v=%b room=%b fl=%h irq=%b",
                       got.tx_line, got.rx_byte, got.rx_byte_valid, got.tx_room,
                       got.status_flags, got.irq);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expected_words.push_back(uart_tick(in_ch.data));
    end
  end

endmodule

@@ test/uart_with_fifos_and_irq_flags_top_tb.sv @@
`timescale 1ns / 1ps

module uart_with_fifos_and_irq_flags_top_tb;
  import uwf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycles = 0;

  // idling of the two sides, changed per phase
  bit          send_idle = 0, recv_stall = 0;
  int unsigned idle_pct = 75;
  // stimulus-side view of the serial format
  int unsigned per = 2604, nbits = 8, par_mode = 0;
  int unsigned pop_pct = 20;
  int unsigned word_count = 0;

  uwf_in_if  in_ch ();
  uwf_out_if out_ch ();

  uart_with_fifos_and_irq_flags_top dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  uwf_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // receiver side: random stalls when enabled
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= recv_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hand one word to the block, waiting for the handshake
  task automatic send_word(in_word_t w);
    while (send_idle && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    word_count++;
  endtask

  task automatic send_cmd(cmd_t c, logic line, logic [7:0] b, logic [3:0] fi);
    in_word_t w;
    w.cmd = c; w.rx_line = line; w.tx_byte = b; w.flag_index = fi;
    send_word(w);
  endtask

  // random access riding on a given rx line level
  task automatic send_level(logic line, int unsigned n);
    int unsigned r;
    cmd_t c;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < pop_pct) c = CMD_POP;
      else if (r < pop_pct + 20) c = CMD_PUSH;
      else if (r < pop_pct + 27) c = CMD_CLEAR;
      else c = CMD_TICK;
      send_cmd(c, line, 8'($urandom), 4'($urandom_range(15)));
    end
  endtask

  // one serial frame on the rx line: good, bad parity, bad stop or false start
  task automatic rx_frame();
    logic [7:0]  b;
    int unsigned kind, eff_n, i;
    logic        p;
    b = 8'($urandom);
    kind = $urandom_range(9);
    eff_n = nbits < 1 ? 1 : (nbits > 8 ? 8 : nbits);
    if (kind == 0) begin
      // one-word low glitch, then long idle for the lockout
      send_level(1'b0, 1);
      send_level(1'b1, 21 * per + 2);
      return;
    end
    send_level(1'b0, per);
    p = 1'b0;
    for (i = 0; i < eff_n; i++) begin
      send_level(b[i], per);
      p ^= b[i];
    end
    if (par_mode == PAR_ODD || par_mode == PAR_EVEN)
      send_level(((par_mode == PAR_ODD) ? ~p : p) ^ (kind == 1), per);
    if (kind == 2) send_level(1'b0, per + $urandom_range(2 * per));
    send_level(1'b1, per + $urandom_range(2 * per));
  endtask

  // register writes only with the block drained
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PERIOD: per = val < 2 ? 2 : val;
      CFG_NBITS:  nbits = val[3:0];
      CFG_PARITY: par_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_format(logic [15:0] p, logic [3:0] n, logic [1:0] pm,
                            logic [4:0] rt, logic [4:0] tt, logic [9:0] m);
    write_reg(CFG_PERIOD, p);
    write_reg(CFG_NBITS, n);
    write_reg(CFG_PARITY, pm);
    write_reg(CFG_RX_THR, rt);
    write_reg(CFG_TX_THR, tt);
    write_reg(CFG_IRQ_EN, m);
  endtask

  // random traffic: mostly well-formed frames, some line noise
  task automatic random_traffic(int unsigned n_words);
    int unsigned stop_at;
    stop_at = word_count + n_words;
    while (word_count < stop_at) begin
      if ($urandom_range(9) < 8) rx_frame();
      else send_cmd(cmd_t'($urandom_range(3)), 1'($urandom), 8'($urandom),
                    4'($urandom_range(15)));
      send_level(1'b1, 2);
    end
  endtask

  initial begin
    int ph;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: slow default period, only accesses and a quiet line
    send_cmd(CMD_POP, 1'b1, 8'h00, 4'd0);
    send_cmd(CMD_CLEAR, 1'b1, 8'h00, 4'd15);
    send_cmd(CMD_CLEAR, 1'b1, 8'h00, 4'd10);
    send_cmd(CMD_CLEAR, 1'b1, 8'h00, 4'd9);
    send_cmd(CMD_CLEAR, 1'b1, 8'h00, 4'd6);
    send_cmd(CMD_TICK, 1'b1, 8'hff, 4'd0);

    // fast line, push 18 extreme bytes into the tx fifo as the transmitter drains it
    set_format(16'd0, 4'd0, 2'd3, 5'd0, 5'd31, 10'h3ff);
    for (int i = 0; i < 18; i++)
      send_cmd(CMD_PUSH, 1'b1, (i % 2) ? 8'hff : 8'h00, 4'd0);
    send_level(1'b1, 40);

    // longest period: accesses only, line stays high, no transmission started
    set_format(16'hffff, 4'd15, 2'd1, 5'd16, 5'd16, 10'h000);
    send_cmd(CMD_POP, 1'b1, 8'h00, 4'd0);
    send_cmd(CMD_CLEAR, 1'b1, 8'h00, 4'd9);
    send_cmd(CMD_TICK, 1'b1, 8'h00, 4'd0);

    // phases: no idling, sender idle, receiver stall, both
    for (ph = 0; ph < 8; ph++) begin
      send_idle = (ph % 4 == 1) || (ph % 4 == 3);
      recv_stall = (ph % 4 == 2) || (ph % 4 == 3);
      idle_pct = (ph % 4 == 3) ? 22 : 75;
      pop_pct = (ph % 3 == 0) ? 2 : 20;
      case (ph)
        0: set_format(16'd4, 4'd8, 2'd0, 5'd1, 5'd1, 10'h3ff);
        1: set_format(16'd2, 4'd1, 2'd1, 5'd16, 5'd0, 10'h155);
        2: set_format(16'd5, 4'd7, 2'd2, 5'd31, 5'd16, 10'h2aa);
        3: set_format(16'd1, 4'd12, 2'd3, 5'd0, 5'd31, 10'h000);
        default: set_format(16'($urandom_range(2, 6)), 4'($urandom_range(1, 8)),
                            2'($urandom_range(3)), 5'($urandom_range(31)),
                            5'($urandom_range(31)), 10'($urandom));
      endcase
      random_traffic(150);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/uwf_pkg.sv
hdl/uwf_if.sv
hdl/uwf_rx.sv
hdl/uart_with_fifos_and_irq_flags_top.sv
test/uwf_checker.sv
test/uart_with_fifos_and_irq_flags_top_tb.sv
